>>> rtl/apf_pkg.sv
// Shared types and codes for the articulation point finder.
package apf_pkg;

  localparam int FW = 11;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_QRY  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SELF = 2'd2;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_ADD0,
    S_ADD1,
    S_ADD2,
    S_CLR,
    S_ROOT_RD,
    S_ROOT_CHK,
    S_LOADH,
    S_STEP,
    S_E2,
    S_E3,
    S_POP1,
    S_POP2,
    S_CNT_RD,
    S_CNT_ACC,
    S_QRY0,
    S_QRY1,
    S_RESP
  } state_t;

  typedef struct packed {
    state_t state;
    logic   accept;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic past_n;
    logic add_ok;
    logic vis;
    logic e_zero;
    logic sp_one;
    logic v_par;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/apf_ctrl.sv
// Controller state machine that sequences edge loads, the walk, counting and queries.
module apf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_operation,
  input  apf_pkg::sts_t       sts,
  output logic                in_ready,
  output apf_pkg::cmd_t       cmd
);

  apf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apf_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.state    = state_r;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    in_ready     = (state_r == apf_pkg::S_IDLE);
    unique case (state_r)
      apf_pkg::S_INIT: begin
        if (sts.sweep_last) state_nxt = apf_pkg::S_IDLE;
      end
      apf_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_operation)
            apf_pkg::OP_ADD: state_nxt = apf_pkg::S_ADD0;
            apf_pkg::OP_RUN: state_nxt = apf_pkg::S_CLR;
            apf_pkg::OP_QRY: state_nxt = apf_pkg::S_QRY0;
            default:         state_nxt = apf_pkg::S_RESP;
          endcase
        end
      end
      apf_pkg::S_ADD0: state_nxt = sts.add_ok ? apf_pkg::S_ADD1 : apf_pkg::S_RESP;
      apf_pkg::S_ADD1: state_nxt = apf_pkg::S_ADD2;
      apf_pkg::S_ADD2: state_nxt = apf_pkg::S_RESP;
      apf_pkg::S_CLR: begin
        if (sts.sweep_last) state_nxt = apf_pkg::S_ROOT_RD;
      end
      apf_pkg::S_ROOT_RD: begin
        state_nxt = sts.past_n ? apf_pkg::S_CNT_RD : apf_pkg::S_ROOT_CHK;
      end
      apf_pkg::S_ROOT_CHK: state_nxt = sts.vis ? apf_pkg::S_ROOT_RD : apf_pkg::S_LOADH;
      apf_pkg::S_LOADH:    state_nxt = apf_pkg::S_STEP;
      apf_pkg::S_STEP: begin
        if (!sts.e_zero) state_nxt = apf_pkg::S_E2;
        else if (sts.sp_one) state_nxt = apf_pkg::S_ROOT_RD;
        else state_nxt = apf_pkg::S_POP1;
      end
      apf_pkg::S_E2:      state_nxt = sts.v_par ? apf_pkg::S_STEP : apf_pkg::S_E3;
      apf_pkg::S_E3:      state_nxt = sts.vis ? apf_pkg::S_STEP : apf_pkg::S_LOADH;
      apf_pkg::S_POP1:    state_nxt = apf_pkg::S_POP2;
      apf_pkg::S_POP2:    state_nxt = apf_pkg::S_STEP;
      apf_pkg::S_CNT_RD:  state_nxt = sts.past_n ? apf_pkg::S_RESP : apf_pkg::S_CNT_ACC;
      apf_pkg::S_CNT_ACC: state_nxt = apf_pkg::S_CNT_RD;
      apf_pkg::S_QRY0:    state_nxt = apf_pkg::S_QRY1;
      apf_pkg::S_QRY1:    state_nxt = apf_pkg::S_RESP;
      apf_pkg::S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = apf_pkg::S_IDLE;
        end
      end
      default: state_nxt = apf_pkg::S_INIT;
    endcase
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r != apf_pkg::S_IDLE))
    else $error("transaction accepted but controller stayed idle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_walk_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == apf_pkg::S_CLR) && !$past(state_r == apf_pkg::S_CLR) |->
    $past(state_r == apf_pkg::S_IDLE))
    else $error("clear sweep entered from a busy state");

endmodule

>>> rtl/apf_dp.sv
// Datapath with graph, walk and mark memories, walk registers and the result register.
module apf_dp #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  apf_pkg::cmd_t           cmd,
  input  logic [apf_pkg::FW-1:0]  in_node_a,
  input  logic [apf_pkg::FW-1:0]  in_node_b,
  input  logic                    cfg_we,
  input  logic [apf_pkg::FW-1:0]  cfg_data,
  input  logic                    out_ready,
  output apf_pkg::sts_t           sts,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [apf_pkg::FW-1:0]  out_cut_count,
  output logic                    out_is_cut
);

  localparam int ND    = MAX_NODES + 1;
  localparam int NW    = $clog2(ND);
  localparam int XW    = NW + 1;
  localparam int SLOTS = 2 * MAX_EDGES;
  localparam int EW    = $clog2(SLOTS + 1);
  localparam int EIW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW    = $clog2(MAX_NODES);

  logic [apf_pkg::FW-1:0] node_count_r;
  logic [apf_pkg::FW-1:0] a_r, b_r;
  logic [XW-1:0]          idx_r;
  logic [EW-1:0]          fill_r;
  logic [NW-1:0]          time_r, sp_r;
  logic [NW-1:0]          cur_u_r, cur_par_r, cur_low_r, cur_child_r, v_r, p_r;
  logic [EW-1:0]          cur_e_r, pe_r;
  logic [1:0]             res_status_r;
  logic [NW-1:0]          res_cnt_r;
  logic                   res_cut_r;
  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [apf_pkg::FW-1:0] out_cnt_r;
  logic                   out_cut_r;

  logic [NW-1:0] n_eff, a_idx, b_idx, i_idx, time_inc;
  logic          a_ok, b_ok, self_e, full_e, past_n;
  assign n_eff    = (32'(node_count_r) > MAX_NODES) ? NW'(MAX_NODES) : NW'(node_count_r);
  assign a_idx    = NW'(a_r);
  assign b_idx    = NW'(b_r);
  assign i_idx    = idx_r[NW-1:0];
  assign time_inc = time_r + NW'(1);
  assign a_ok     = (a_r != '0) && (32'(a_r) <= MAX_NODES);
  assign b_ok     = (b_r != '0) && (32'(b_r) <= MAX_NODES);
  assign self_e   = (a_r == b_r);
  assign full_e   = (32'(fill_r) + 32'd2) > SLOTS;
  assign past_n   = idx_r > {1'b0, n_eff};

  logic st_add0, st_add1, st_add2, st_clr, st_init, st_root_rd, st_root_chk;
  logic st_step, st_e2, st_e3, st_pop1, st_pop2, st_cnt_rd, st_qry0;
  assign st_init     = (cmd.state == apf_pkg::S_INIT);
  assign st_add0     = (cmd.state == apf_pkg::S_ADD0);
  assign st_add1     = (cmd.state == apf_pkg::S_ADD1);
  assign st_add2     = (cmd.state == apf_pkg::S_ADD2);
  assign st_clr      = (cmd.state == apf_pkg::S_CLR);
  assign st_root_rd  = (cmd.state == apf_pkg::S_ROOT_RD);
  assign st_root_chk = (cmd.state == apf_pkg::S_ROOT_CHK);
  assign st_step     = (cmd.state == apf_pkg::S_STEP);
  assign st_e2       = (cmd.state == apf_pkg::S_E2);
  assign st_e3       = (cmd.state == apf_pkg::S_E3);
  assign st_pop1     = (cmd.state == apf_pkg::S_POP1);
  assign st_pop2     = (cmd.state == apf_pkg::S_POP2);
  assign st_cnt_rd   = (cmd.state == apf_pkg::S_CNT_RD);
  assign st_qry0     = (cmd.state == apf_pkg::S_QRY0);

  // Memories: one write port and one registered read port each.
  logic [EW-1:0]  head_mem  [ND];
  logic           vis_mem   [ND];
  logic [NW-1:0]  disc_mem  [ND];
  logic [NW-1:0]  low_mem   [ND];
  logic [NW-1:0]  par_mem   [ND];
  logic [NW-1:0]  child_mem [ND];
  logic           cut_mem   [ND];
  logic [EW-1:0]  enext_mem [SLOTS];
  logic [NW-1:0]  edest_mem [SLOTS];
  logic [NW-1:0]  stkn_mem  [MAX_NODES];
  logic [EW-1:0]  stke_mem  [MAX_NODES];

  logic [EW-1:0]  head_rd, enext_rd, stke_rd;
  logic           vis_rd, cut_rd;
  logic [NW-1:0]  disc_rd, low_rd, par_rd, child_rd, edest_rd, stkn_rd;

  logic            head_we, vis_we, vis_wd, disc_we, low_we, par_we, child_we, cut_we, cut_wd;
  logic            edge_we, stk_we;
  logic [NW-1:0]   head_ra, head_wa, vis_ra, vis_wa, disc_ra, disc_wa, node_ra;
  logic [NW-1:0]   par_wa, par_wd, cut_ra, cut_wa;
  logic [EW-1:0]   head_wd, enext_wd;
  logic [NW-1:0]   edest_wd;
  logic [EIW-1:0]  edge_ra, edge_wa;
  logic [SW-1:0]   stk_ra, stk_wa;
  logic [EW-1:0]   fill_p1, fill_p2, e_m1;
  logic [NW-1:0]   sp_m1, sp_m2;

  assign fill_p1 = fill_r + EW'(1);
  assign fill_p2 = fill_r + EW'(2);
  assign e_m1    = cur_e_r - EW'(1);
  assign sp_m1   = sp_r - NW'(1);
  assign sp_m2   = sp_r - NW'(2);

  always_comb begin
    head_ra = st_add0 ? a_idx : st_add1 ? b_idx : st_root_chk ? i_idx : v_r;
    head_we = st_init || st_add1 || st_add2;
    head_wa = st_init ? i_idx : st_add1 ? a_idx : b_idx;
    head_wd = st_init ? '0 : st_add1 ? fill_p1 : fill_p2;

    vis_ra  = st_root_rd ? i_idx : edest_rd;
    vis_we  = st_clr || (st_root_chk && !vis_rd) || (st_e3 && !vis_rd);
    vis_wa  = st_e3 ? v_r : i_idx;
    vis_wd  = !st_clr;

    disc_ra = st_pop1 ? stkn_rd : edest_rd;
    disc_we = (st_root_chk || st_e3) && !vis_rd;
    disc_wa = st_e3 ? v_r : i_idx;

    node_ra = stkn_rd;
    low_we  = st_e3 && !vis_rd;
    child_we = low_we;
    par_we  = (st_root_chk || st_e3) && !vis_rd;
    par_wa  = st_e3 ? v_r : i_idx;
    par_wd  = st_e3 ? cur_u_r : '0;

    cut_ra  = st_qry0 ? a_idx : i_idx;
    cut_we  = st_init || st_clr ||
              (st_step && cur_e_r == '0 && cur_par_r == '0 && cur_child_r > NW'(1)) ||
              (st_pop2 && par_rd != '0 && cur_low_r >= disc_rd);
    cut_wa  = (st_init || st_clr) ? i_idx : st_step ? cur_u_r : p_r;
    cut_wd  = !(st_init || st_clr);

    edge_ra  = e_m1[EIW-1:0];
    edge_we  = st_add1 || st_add2;
    edge_wa  = st_add1 ? fill_r[EIW-1:0] : fill_p1[EIW-1:0];
    edest_wd = st_add1 ? b_idx : a_idx;
    enext_wd = head_rd;

    stk_ra = sp_m2[SW-1:0];
    stk_we = st_e3 && !vis_rd;
    stk_wa = sp_m1[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (disc_we) disc_mem[disc_wa] <= time_inc;
    disc_rd <= disc_mem[disc_ra];
  end

  always_ff @(posedge clk) begin
    if (low_we) low_mem[cur_u_r] <= cur_low_r;
    low_rd <= low_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_rd <= par_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (child_we) child_mem[cur_u_r] <= cur_child_r + NW'(1);
    child_rd <= child_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (cut_we) cut_mem[cut_wa] <= cut_wd;
    cut_rd <= cut_mem[cut_ra];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      enext_mem[edge_wa] <= enext_wd;
      edest_mem[edge_wa] <= edest_wd;
    end
    enext_rd <= enext_mem[edge_ra];
    edest_rd <= edest_mem[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stkn_mem[stk_wa] <= cur_u_r;
      stke_mem[stk_wa] <= cur_e_r;
    end
    stkn_rd <= stkn_mem[stk_ra];
    stke_rd <= stke_mem[stk_ra];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= apf_pkg::FW'(1);
      idx_r        <= '0;
      fill_r       <= '0;
      time_r       <= '0;
      sp_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) node_count_r <= cfg_data;
      if (cmd.accept) idx_r <= '0;
      else if (st_init) idx_r <= idx_r + XW'(1);
      else if (st_clr) idx_r <= sts.sweep_last ? XW'(1) : idx_r + XW'(1);
      else if (st_root_rd && past_n) idx_r <= XW'(1);
      else if (st_root_chk && vis_rd) idx_r <= idx_r + XW'(1);
      else if (st_step && cur_e_r == '0 && sp_r == NW'(1)) idx_r <= idx_r + XW'(1);
      else if (cmd.state == apf_pkg::S_CNT_ACC) idx_r <= idx_r + XW'(1);

      if (st_add2) fill_r <= fill_p2;

      if (st_clr) time_r <= '0;
      else if (disc_we) time_r <= time_inc;

      if (st_root_chk && !vis_rd) sp_r <= NW'(1);
      else if (st_e3 && !vis_rd) sp_r <= sp_r + NW'(1);
      else if (st_step && cur_e_r == '0) sp_r <= sp_m1;

      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Walk and result registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      a_r          <= in_node_a;
      b_r          <= in_node_b;
      res_status_r <= apf_pkg::ST_OK;
      res_cnt_r    <= '0;
      res_cut_r    <= 1'b0;
    end
    if (st_add0) begin
      if (self_e) res_status_r <= apf_pkg::ST_SELF;
      else if (a_ok && b_ok && full_e) res_status_r <= apf_pkg::ST_FULL;
    end
    if (cmd.state == apf_pkg::S_QRY1) res_cut_r <= a_ok && cut_rd;
    if (cmd.state == apf_pkg::S_CNT_ACC) res_cnt_r <= res_cnt_r + NW'(cut_rd);
    if (st_root_chk && !vis_rd) begin
      cur_u_r     <= i_idx;
      cur_par_r   <= '0;
      cur_low_r   <= time_inc;
      cur_child_r <= '0;
    end
    if (cmd.state == apf_pkg::S_LOADH) cur_e_r <= head_rd;
    if (st_e2) begin
      v_r     <= edest_rd;
      cur_e_r <= enext_rd;
    end
    if (st_e3) begin
      if (!vis_rd) begin
        cur_u_r     <= v_r;
        cur_par_r   <= cur_u_r;
        cur_low_r   <= time_inc;
        cur_child_r <= '0;
      end else if (disc_rd < cur_low_r) begin
        cur_low_r <= disc_rd;
      end
    end
    if (st_pop1) begin
      p_r  <= stkn_rd;
      pe_r <= stke_rd;
    end
    if (st_pop2) begin
      cur_u_r     <= p_r;
      cur_e_r     <= pe_r;
      cur_par_r   <= par_rd;
      cur_child_r <= child_rd;
      if (low_rd < cur_low_r) cur_low_r <= low_rd;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_cnt_r    <= apf_pkg::FW'(res_cnt_r);
      out_cut_r    <= res_cut_r;
    end
  end

  assign sts.sweep_last = (idx_r == XW'(MAX_NODES));
  assign sts.past_n     = past_n;
  assign sts.add_ok     = !self_e && a_ok && b_ok && !full_e;
  assign sts.vis        = vis_rd;
  assign sts.e_zero     = (cur_e_r == '0);
  assign sts.sp_one     = (sp_r == NW'(1));
  assign sts.v_par      = (edest_rd == cur_par_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_cut_count = out_cnt_r;
  assign out_is_cut    = out_cut_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= MAX_NODES)
    else $error("walk stack overflow");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= SLOTS)
    else $error("edge table fill past its depth");

  a_time_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(time_r) <= MAX_NODES)
    else $error("entry time past node count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    st_pop1 |-> (sp_r != '0))
    else $error("pop from an empty walk stack");

endmodule

>>> rtl/articulation_point_finder.sv
// Top level of the articulation point finder: controller plus datapath.
// Run: a clear sweep, then a walk from each unvisited start candidate over its adjacency entries
// with returns up the walk stack, then a count over the nodes.
// One transaction at a time; the next can be accepted in the cycle after a result loads, even if it waits.
// Reset is synchronous; afterwards a sweep clears adjacency and marks.
module articulation_point_finder #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_operation,
  input  logic [apf_pkg::FW-1:0]  in_node_a,
  input  logic [apf_pkg::FW-1:0]  in_node_b,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [apf_pkg::FW-1:0]  out_cut_count,
  output logic                    out_is_cut,
  input  logic                    cfg_we,
  input  logic [apf_pkg::FW-1:0]  cfg_data
);

  apf_pkg::cmd_t cmd;
  apf_pkg::sts_t sts;

  apf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .sts          (sts),
    .in_ready     (in_ready),
    .cmd          (cmd)
  );

  apf_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_node_a     (in_node_a),
    .in_node_b     (in_node_b),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .out_ready     (out_ready),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_cut_count (out_cut_count),
    .out_is_cut    (out_is_cut)
  );

endmodule
